// ===== hdl/json_string_unescape_top_macros.svh =====
// ---------------------------------------------------------------------------
// json string unescape assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define JSU_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define JSU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define JSU_ASSERT_SAME(label, ante, cons)
`define JSU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/jsu_pkg.sv =====
// ---------------------------------------------------------------------------
// jsu_pkg
// shared types, codes and helpers of the json string unescape block
// ---------------------------------------------------------------------------
package jsu_pkg;

	localparam int UNIT_W  = 21;
	localparam int KIND_W  = 2;
	localparam int PHASE_W = 3;

	// decoder phases
	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_BODY    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_ESC     = 3'd2;
	localparam logic [PHASE_W-1:0] PH_HEX_A   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_PAIR_BS = 3'd4;
	localparam logic [PHASE_W-1:0] PH_PAIR_U  = 3'd5;
	localparam logic [PHASE_W-1:0] PH_HEX_B   = 3'd6;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

	// characters of interest
	localparam logic [UNIT_W-1:0] CH_QUOTE  = 21'h22;
	localparam logic [UNIT_W-1:0] CH_BSLASH = 21'h5c;
	localparam logic [UNIT_W-1:0] CH_SLASH  = 21'h2f;
	localparam logic [UNIT_W-1:0] CH_B      = 21'h62;
	localparam logic [UNIT_W-1:0] CH_F      = 21'h66;
	localparam logic [UNIT_W-1:0] CH_N      = 21'h6e;
	localparam logic [UNIT_W-1:0] CH_R      = 21'h72;
	localparam logic [UNIT_W-1:0] CH_T      = 21'h74;
	localparam logic [UNIT_W-1:0] CH_U      = 21'h75;
	localparam logic [UNIT_W-1:0] CH_SPACE  = 21'h20;
	localparam logic [UNIT_W-1:0] CP_MAX    = 21'h10ffff;
	localparam logic [UNIT_W-1:0] CP_PLANE1 = 21'h10000;

	localparam logic [15:0] HI_SUR_LO = 16'hd800;
	localparam logic [15:0] HI_SUR_HI = 16'hdbff;
	localparam logic [15:0] LO_SUR_LO = 16'hdc00;
	localparam logic [15:0] LO_SUR_HI = 16'hdfff;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [1:0]         hex_count;
		logic [15:0]        hex_acc;
		logic [9:0]         high_sur;   // high surrogate minus 0xd800
	} dec_state_t;

	typedef struct packed {
		logic              has;
		logic [UNIT_W-1:0] code_point;
		logic [KIND_W-1:0] kind;
	} dec_result_t;

	// hex digit: bit 4 set when the unit is a valid digit, low nibble its value
	function automatic logic [4:0] hex_digit(input logic [UNIT_W-1:0] u);
		logic [4:0] r;
		r = 5'd0;
		if (u >= 21'h30 && u <= 21'h39) begin
			r = {1'b1, u[3:0]};
		end else if ((u >= 21'h61 && u <= 21'h66) || (u >= 21'h41 && u <= 21'h46)) begin
			r = {1'b1, u[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// ===== hdl/jsu_decode.sv =====
// ---------------------------------------------------------------------------
// jsu_decode
// next-state and result logic for one code unit of a json string literal
// ---------------------------------------------------------------------------
module jsu_decode (
	input  jsu_pkg::dec_state_t              state,
	input  logic [jsu_pkg::UNIT_W-1:0]       unit,
	input  logic                             eot,
	output jsu_pkg::dec_state_t              next,
	output jsu_pkg::dec_result_t             res
);
	import jsu_pkg::*;

	logic [4:0]  hd;
	logic [15:0] acc_new;
	logic        in_lo_sur;
	logic        in_hi_sur;

	assign hd        = hex_digit(unit);
	assign acc_new   = {state.hex_acc[11:0], hd[3:0]};
	assign in_lo_sur = (acc_new >= LO_SUR_LO) && (acc_new <= LO_SUR_HI);
	assign in_hi_sur = (acc_new >= HI_SUR_LO) && (acc_new <= HI_SUR_HI);

	always_comb begin
		dec_state_t  fail_st;
		dec_result_t err_res;
		fail_st = '{phase: PH_IDLE, hex_count: 2'd0, hex_acc: 16'd0, high_sur: 10'd0};
		err_res = '{has: 1'b1, code_point: '0, kind: KIND_ERR};
		next    = state;
		res     = '{has: 1'b0, code_point: '0, kind: KIND_CHAR};
		if (eot) begin
			next = fail_st;
			res  = err_res;
		end else begin
			case (state.phase)
				PH_IDLE: begin
					if (unit == CH_QUOTE) begin
						next.phase = PH_BODY;
					end else begin
						next = fail_st;
						res  = err_res;
					end
				end
				PH_BODY: begin
					if (unit == CH_QUOTE) begin
						next.phase = PH_IDLE;
						res        = '{has: 1'b1, code_point: '0, kind: KIND_DONE};
					end else if (unit < CH_SPACE || unit > CP_MAX) begin
						next = fail_st;
						res  = err_res;
					end else if (unit == CH_BSLASH) begin
						next.phase = PH_ESC;
					end else begin
						res = '{has: 1'b1, code_point: unit, kind: KIND_CHAR};
					end
				end
				PH_ESC: begin
					next.phase = PH_BODY;
					res        = '{has: 1'b1, code_point: unit, kind: KIND_CHAR};
					case (unit)
						CH_B: res.code_point = 21'h08;
						CH_F: res.code_point = 21'h0c;
						CH_N: res.code_point = 21'h0a;
						CH_R: res.code_point = 21'h0d;
						CH_T: res.code_point = 21'h09;
						CH_BSLASH, CH_SLASH, CH_QUOTE: res.code_point = unit;
						CH_U: begin
							next.phase     = PH_HEX_A;
							next.hex_count = 2'd0;
							next.hex_acc   = 16'd0;
							res.has        = 1'b0;
						end
						default: begin
							next = fail_st;
							res  = err_res;
						end
					endcase
				end
				PH_HEX_A, PH_HEX_B: begin
					if (!hd[4]) begin
						next = fail_st;
						res  = err_res;
					end else if (state.hex_count != 2'd3) begin
						next.hex_count = state.hex_count + 2'd1;
						next.hex_acc   = acc_new;
					end else begin
						next.hex_count = 2'd0;
						next.hex_acc   = 16'd0;
						if (state.phase == PH_HEX_A) begin
							if (in_lo_sur) begin
								next = fail_st;
								res  = err_res;
							end else if (in_hi_sur) begin
								next.high_sur = acc_new[9:0];
								next.phase    = PH_PAIR_BS;
							end else begin
								next.phase = PH_BODY;
								res        = '{has: 1'b1, code_point: {5'd0, acc_new},
									kind: KIND_CHAR};
							end
						end else if (!in_lo_sur) begin
							next = fail_st;
							res  = err_res;
						end else begin
							// pair: 0x10000 + (high << 10) + low
							next.high_sur = 10'd0;
							next.phase    = PH_BODY;
							res           = '{has: 1'b1,
								code_point: CP_PLANE1 + {1'b0, state.high_sur, acc_new[9:0]},
								kind: KIND_CHAR};
						end
					end
				end
				PH_PAIR_BS: begin
					if (unit == CH_BSLASH) begin
						next.phase = PH_PAIR_U;
					end else begin
						next = fail_st;
						res  = err_res;
					end
				end
				PH_PAIR_U: begin
					if (unit == CH_U) begin
						next.phase     = PH_HEX_B;
						next.hex_count = 2'd0;
						next.hex_acc   = 16'd0;
					end else begin
						next = fail_st;
						res  = err_res;
					end
				end
				default: begin
					next = fail_st;
					res  = err_res;
				end
			endcase
		end
	end

endmodule

// ===== hdl/json_string_unescape_top.sv =====
// path: an accepted beat is held in the input register, then its result is loaded into the result register
// throughput: one code unit per cycle, sustained, with out_ready held high
// set by the single decode pass between the input register and the result register
// beats that only advance the decoder (opening quote, backslash, u, most hex digits) give no result
// reset (arst_n low, asynchronous): both registers empty, decoder idle awaiting a quote
// ---------------------------------------------------------------------------
// json_string_unescape_top
// json string literal decoder: one code unit in, at most one code point out
// ---------------------------------------------------------------------------
`include "json_string_unescape_top_macros.svh"

module json_string_unescape_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [jsu_pkg::UNIT_W-1:0]       code_unit,
	input  logic                             end_of_text,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [jsu_pkg::UNIT_W-1:0]       code_point,
	output logic [jsu_pkg::KIND_W-1:0]       kind
);
	import jsu_pkg::*;

	// input register
	logic              valid_s1;
	logic [UNIT_W-1:0] unit_s1;
	logic              eot_s1;

	// decoder state, held across beats
	dec_state_t  state_q;
	dec_state_t  state_next;
	dec_result_t res;

	// result register
	logic              out_valid_q;
	logic [UNIT_W-1:0] code_point_q;
	logic [KIND_W-1:0] kind_q;

	logic advance;

	// the input beat moves on once the result register is free or draining this cycle;
	// beats without a result need no room but keep the rule simple and in order
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	jsu_decode u_decode (
		.state (state_q),
		.unit  (unit_s1),
		.eot   (eot_s1),
		.next  (state_next),
		.res   (res)
	);

	// input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			unit_s1 <= code_unit;
			eot_s1  <= end_of_text;
		end
	end

	// decoder state updates once per beat leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, hex_count: 2'd0, hex_acc: 16'd0, high_sur: 10'd0};
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.has) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (advance && res.has) begin
			code_point_q <= res.code_point;
			kind_q       <= res.kind;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = code_point_q;
	assign kind       = kind_q;

	// a decoded result always reaches the result register
	`JSU_ASSERT_NEXT(a_result_loaded, advance && res.has, out_valid_q)
	// completion and error beats carry a zero code point
	`JSU_ASSERT_SAME(a_status_zero_cp, out_valid_q && kind_q != KIND_CHAR, code_point_q == '0)
	// decoded characters stay within the unicode range
	`JSU_ASSERT_SAME(a_cp_in_range, out_valid_q && kind_q == KIND_CHAR, code_point_q <= CP_MAX)
	// hex collection is clear outside the hex phases
	`JSU_ASSERT_SAME(a_hex_clear,
		state_q.phase != PH_HEX_A && state_q.phase != PH_HEX_B,
		state_q.hex_count == 2'd0 && state_q.hex_acc == 16'd0)
	// an empty input register always takes a beat
	`JSU_ASSERT_SAME(a_ready_when_empty, !valid_s1, in_ready)

endmodule
